// ===== sv/twts_pkg.sv =====
// Package with types, constants and codes for the timing wheel scheduler.
`timescale 1ns / 1ps
`default_nettype none
package twts_pkg;
  localparam int MaxTasks = 16;
  localparam int WheelSlots = 32;
  localparam int IdW = $clog2(MaxTasks);
  localparam int LinkW = $clog2(MaxTasks + 1);
  localparam int SlotW = $clog2(WheelSlots);
  localparam int CntW = $clog2(MaxTasks + 1);
  localparam logic [LinkW-1:0] NoTask = LinkW'(MaxTasks);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_DEL    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_DUE      = 3'd0;
  localparam logic [2:0] ST_NONE_DUE = 3'd1;
  localparam logic [2:0] ST_ADDED    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] delay;
    logic [4:0] period;
    logic [3:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] task_id;
    logic       last;
    logic [4:0] tasks_in_use;
  } out_item_t;
endpackage
`default_nettype wire

// ===== sv/timing_wheel_task_scheduler_core.sv =====
// Top level of the timing wheel scheduler: sequencer around slot and link memories.
// A full table or an unknown delete id is answered at acceptance; an add answers once its
//   slot head is read and rewritten; a delete searches the slot lists for the task and
//   answers after unlinking it. A tick gives one none-due result when nothing is due, else
//   one result per due task; an unused kind gets no answer. Output stalls hold results back.
// One item at a time. After reset a clearing pass writes every slot head empty, one
//   slot per cycle, while no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module timing_wheel_task_scheduler_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire twts_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output twts_pkg::out_item_t        out_data
);
  import twts_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_TRD   = 15'b000000000000100,
    S_THEAD = 15'b000000000001000,
    S_TCHK  = 15'b000000000010000,
    S_TLNK  = 15'b000000000100000,
    S_TPUSH = 15'b000000001000000,
    S_ARD   = 15'b000000010000000,
    S_AWR   = 15'b000000100000000,
    S_DRD   = 15'b000001000000000,
    S_DHEAD = 15'b000010000000000,
    S_DCHK  = 15'b000100000000000,
    S_DNEXT = 15'b001000000000000,
    S_DFIX  = 15'b010000000000000,
    S_DEND  = 15'b100000000000000
  } state_t;

  state_t              state;
  in_item_t            item;
  logic [MaxTasks-1:0] live;
  logic [CntW-1:0]     count;
  logic [SlotW-1:0]    pos, slot, dest;
  logic [LinkW-1:0]    cur, prev, nxt;
  logic [4:0]          per;
  logic [CntW-1:0]     steps;
  logic [LinkW-1:0]    free_id;
  logic                out_busy;
  logic                out_free;
  logic                accept;
  logic                add_full;
  logic                last_due;
  logic                emit;
  out_item_t           out_next;

  logic [LinkW-1:0] heads [WheelSlots];
  logic [SlotW-1:0] h_addr;
  logic             h_we;
  logic [LinkW-1:0] h_wdata, h_rdata;

  logic [LinkW-1:0] links [MaxTasks];
  logic [4:0]       pers  [MaxTasks];
  logic [IdW-1:0]   l_addr;
  logic             l_we, p_we;
  logic [LinkW-1:0] l_wdata, l_rdata;
  logic [4:0]       p_rdata;

  // Slot head memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (h_we) heads[h_addr] <= h_wdata;
    h_rdata <= heads[h_addr];
  end

  // Link and period memory per task.
  always_ff @(posedge clk) begin
    if (l_we) links[l_addr] <= l_wdata;
    if (p_we) pers[l_addr] <= item.period;
    l_rdata <= links[l_addr];
    p_rdata <= pers[l_addr];
  end

  // Lowest free id.
  always_comb begin
    free_id = NoTask;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!live[i]) free_id = LinkW'(i);
    end
  end

  assign in_stall = (state != S_IDLE) || out_busy;
  assign out_valid = out_busy;
  assign out_free = !out_busy || !out_stall;
  assign accept = in_valid && !in_stall;
  assign add_full = (count >= CntW'(MaxTasks)) || (free_id == NoTask);
  assign last_due = (nxt == NoTask) || (steps == CntW'(MaxTasks - 1));

  // Memory port control and result generation by state.
  always_comb begin
    h_addr = slot; h_we = 1'b0; h_wdata = NoTask;
    l_addr = cur[IdW-1:0]; l_we = 1'b0; l_wdata = h_rdata; p_we = 1'b0;
    emit = 1'b0; out_next = '0;
    unique case (state)
      S_CLEAR: begin h_we = 1'b1; end
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_ADD: begin
              if (add_full) begin
                emit = 1'b1;
                out_next.status = ST_FULL;
                out_next.last = 1'b1;
                out_next.tasks_in_use = count;
              end
            end
            KIND_DEL: begin
              if (!live[in_data.target_id[IdW-1:0]]) begin
                emit = 1'b1;
                out_next.status = ST_NOTFOUND;
                out_next.last = 1'b1;
                out_next.tasks_in_use = count;
              end
            end
            default: begin end
          endcase
        end
      end
      S_TRD: begin h_addr = pos; end
      S_THEAD: begin h_addr = pos; h_we = 1'b1; end
      S_TCHK: begin
        if (cur == NoTask && out_free) begin
          emit = 1'b1;
          out_next.status = ST_NONE_DUE;
          out_next.last = 1'b1;
          out_next.tasks_in_use = count;
        end
      end
      S_TLNK: begin h_addr = pos + SlotW'(p_rdata); end
      S_TPUSH: begin
        h_addr = dest;
        if (out_free) begin
          emit = 1'b1;
          out_next.status = ST_DUE;
          out_next.task_id = cur[IdW-1:0];
          out_next.last = last_due;
          out_next.tasks_in_use = (per == '0) ? count - 1'b1 : count;
          // A periodic task goes to the head of its next slot.
          if (per != '0) begin
            h_we = 1'b1; h_wdata = cur;
            l_we = 1'b1;
          end
        end
      end
      S_ARD: begin h_addr = dest; end
      S_AWR: begin
        h_addr = dest; h_we = 1'b1; h_wdata = cur;
        l_we = 1'b1; p_we = 1'b1;
        emit = 1'b1;
        out_next.status = ST_ADDED;
        out_next.task_id = cur[IdW-1:0];
        out_next.last = 1'b1;
        out_next.tasks_in_use = count + 1'b1;
      end
      S_DRD, S_DHEAD, S_DNEXT: begin end
      S_DCHK: begin
        if (cur == NoTask || steps == CntW'(MaxTasks)) h_addr = slot + 1'b1;
      end
      S_DFIX: begin
        if (prev == NoTask) begin
          h_we = 1'b1; h_wdata = l_rdata;
        end else begin
          l_addr = prev[IdW-1:0]; l_we = 1'b1; l_wdata = l_rdata;
        end
      end
      S_DEND: begin
        emit = 1'b1;
        out_next.status = ST_DELETED;
        out_next.last = 1'b1;
        out_next.tasks_in_use = count - 1'b1;
      end
      default: begin end
    endcase
  end

  // Output register: one transaction held until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
    end else if (emit) begin
      out_busy <= 1'b1;
    end else if (!out_stall) begin
      out_busy <= 1'b0;
    end
    if (emit) out_data <= out_next;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; slot <= '0; pos <= '0; live <= '0; count <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == SlotW'(WheelSlots - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            item <= in_data;
            case (in_data.kind)
              KIND_TICK: state <= S_TRD;
              KIND_ADD: begin
                if (!add_full) begin
                  cur <= free_id;
                  dest <= pos + SlotW'(in_data.delay);
                  state <= S_ARD;
                end
              end
              KIND_DEL: begin
                if (live[in_data.target_id[IdW-1:0]]) begin
                  slot <= '0; state <= S_DRD;
                end
              end
              default: begin end
            endcase
          end
        end
        S_TRD: state <= S_THEAD;
        S_THEAD: begin
          // The current slot list is detached here.
          cur <= h_rdata; steps <= '0; state <= S_TCHK;
        end
        S_TCHK: begin
          if (cur == NoTask) begin
            if (out_free) begin
              pos <= pos + 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_TLNK;
          end
        end
        S_TLNK: begin
          nxt <= l_rdata;
          per <= p_rdata;
          dest <= pos + SlotW'(p_rdata);
          state <= S_TPUSH;
        end
        S_TPUSH: begin
          if (out_free) begin
            if (per == '0) begin
              live[cur[IdW-1:0]] <= 1'b0;
              count <= count - 1'b1;
            end
            steps <= steps + 1'b1;
            if (last_due) begin
              pos <= pos + 1'b1;
              state <= S_IDLE;
            end else begin
              cur <= nxt;
              state <= S_TCHK;
            end
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          live[cur[IdW-1:0]] <= 1'b1;
          count <= count + 1'b1;
          state <= S_IDLE;
        end
        S_DRD: begin
          prev <= NoTask; steps <= '0; state <= S_DHEAD;
        end
        S_DHEAD: begin
          cur <= h_rdata; state <= S_DCHK;
        end
        S_DCHK: begin
          // End of a list moves on to the next slot, whose head read starts now.
          if (cur == NoTask || steps == CntW'(MaxTasks)) begin
            if (slot == SlotW'(WheelSlots - 1)) begin
              state <= S_DEND;
            end else begin
              slot <= slot + 1'b1;
              prev <= NoTask; steps <= '0;
              state <= S_DHEAD;
            end
          end else if (cur[IdW-1:0] == item.target_id[IdW-1:0]) begin
            state <= S_DFIX;
          end else begin
            prev <= cur; steps <= steps + 1'b1;
            state <= S_DNEXT;
          end
        end
        S_DNEXT: begin
          cur <= l_rdata; state <= S_DCHK;
        end
        S_DFIX: state <= S_DEND;
        S_DEND: begin
          live[item.target_id[IdW-1:0]] <= 1'b0;
          count <= count - 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
